/* rtl/alpha_blend_argb32_pixel_top_assert.svh */
// Assertion macros for the ARGB alpha blend block.
// Included by the top level; no other dependencies.
`ifndef ALPHA_BLEND_ARGB32_PIXEL_TOP_ASSERT_SVH
`define ALPHA_BLEND_ARGB32_PIXEL_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define ABP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("abp assertion failed");
`define ABP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("abp assertion failed");
`else
`define ABP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define ABP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/abp_pkg.sv */
// Package for the ARGB alpha blend block: widths, constants, stage types.
// No dependencies.
package abp_pkg;

  localparam int PIXEL_W = 32;
  localparam int GA_W    = 9;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [GA_W-1:0] GA_RESET   = 9'd256;
  localparam logic [8:0]      ALPHA_FULL = 9'd255;

  localparam logic [0:0] REG_GLOBAL_ALPHA = 1'b0;

  typedef struct packed {
    logic [PIXEL_W-1:0] src;
    logic [PIXEL_W-1:0] dst;
    logic [7:0]         g;
    logic               zero;
    logic               full;
  } s1_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] src;
    logic [PIXEL_W-1:0] dst;
    logic [7:0]         g;
    logic               zero;
    logic               full;
    logic [3:0][15:0]   prod;
  } s2_t;

endpackage

/* rtl/abp_if.sv */
// Valid/ready channel interfaces for the ARGB alpha blend block.
// Depends on abp_pkg for the pixel width.
interface abp_in_if;
  logic                       valid;
  logic                       ready;
  logic [abp_pkg::PIXEL_W-1:0] source_pixel;
  logic [abp_pkg::PIXEL_W-1:0] dest_pixel;

  modport source (output valid, output source_pixel, output dest_pixel, input ready);
  modport sink   (input valid, input source_pixel, input dest_pixel, output ready);
endinterface

interface abp_out_if;
  logic                       valid;
  logic                       ready;
  logic [abp_pkg::PIXEL_W-1:0] result_pixel;
  logic                       write_enable;

  modport source (output valid, output result_pixel, output write_enable, input ready);
  modport sink   (input valid, input result_pixel, input write_enable, output ready);
endinterface

/* rtl/alpha_blend_argb32_pixel_top.sv */
// Top level of the ARGB alpha blend block: three-stage blend pipeline and APB register.
// Depends on abp_pkg, abp_if.sv and alpha_blend_argb32_pixel_top_assert.svh.
//
// Blends one ARGB8888 source pixel over one destination pixel per beat under a
// 9-bit global alpha (register 0, byte address 0, reset 256). Effective alpha is
// (source alpha * global alpha) >> 8; zero gives write_enable 0 with the
// destination passed through, 255 or more writes the source unchanged, and
// anything between mixes all four bytes with saturation to 0..255. One beat is
// accepted per clock unless back-pressure stalls the pipeline; each result passes
// three registered stages in order: stage one forms the effective alpha multiply,
// stage two the four per-byte 8x8 multiplies, stage three the add, saturate and
// select. Each stage holds its beat only while the stage behind it is full and
// stalled, so back-pressure costs no throughput once the consumer takes beats
// again. Write global alpha only while the pipeline is empty.
`include "alpha_blend_argb32_pixel_top_assert.svh"

module alpha_blend_argb32_pixel_top (
  input  logic                         clk,
  input  logic                         rst_n,
  abp_in_if.sink                       in_ch,
  abp_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [abp_pkg::ADDR_W-1:0]   paddr,
  input  logic [abp_pkg::DATA_W-1:0]   pwdata,
  output logic [abp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [abp_pkg::GA_W-1:0] ga_r;
  logic [abp_pkg::GA_W-1:0] ga_nxt;
  logic                     ga_we;

  logic         v1_r, v2_r, v3_r;
  logic         rdy1, rdy2, rdy3;
  abp_pkg::s1_t s1_r, s1_nxt;
  abp_pkg::s2_t s2_r, s2_nxt;
  logic [abp_pkg::PIXEL_W-1:0] res3_r, res3_nxt;
  logic         we3_r, we3_nxt;

  logic [16:0]  amul;
  logic [8:0]   alpha_eff;

  // register port
  assign pready = 1'b1;
  assign ga_we  = psel && penable && pwrite && (paddr[2] == abp_pkg::REG_GLOBAL_ALPHA);
  assign ga_nxt = pwdata[abp_pkg::GA_W-1:0];

  always_comb begin
    prdata = '0;
    if (paddr[2] == abp_pkg::REG_GLOBAL_ALPHA) begin
      prdata = abp_pkg::DATA_W'(ga_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ga_r <= abp_pkg::GA_RESET;
    end else if (ga_we) begin
      ga_r <= ga_nxt;
    end
  end

  // stage handshake: advance when the next stage is empty or advancing
  assign rdy3         = !v3_r || out_ch.ready;
  assign rdy2         = !v2_r || rdy3;
  assign rdy1         = !v1_r || rdy2;
  assign in_ch.ready  = rdy1;

  // stage 1: effective alpha
  always_comb begin
    amul          = 17'(in_ch.source_pixel[31:24]) * 17'(ga_r);
    alpha_eff     = amul[16:8];
    s1_nxt.src    = in_ch.source_pixel;
    s1_nxt.dst    = in_ch.dest_pixel;
    s1_nxt.zero   = (alpha_eff == 9'd0);
    s1_nxt.full   = (alpha_eff >= abp_pkg::ALPHA_FULL);
    s1_nxt.g      = 8'(abp_pkg::ALPHA_FULL - alpha_eff);
  end

  // stage 2: per-byte products
  always_comb begin
    logic [8:0] dsum;
    s2_nxt.src  = s1_r.src;
    s2_nxt.dst  = s1_r.dst;
    s2_nxt.g    = s1_r.g;
    s2_nxt.zero = s1_r.zero;
    s2_nxt.full = s1_r.full;
    for (int k = 0; k < 4; k++) begin
      dsum = 9'(s1_r.dst[8*k +: 8]) + 9'd255 - 9'(s1_r.src[8*k +: 8]);
      s2_nxt.prod[k] = 16'(dsum[8:1]) * 16'(s1_r.g);
    end
  end

  // stage 3: add, saturate, select
  always_comb begin
    logic [10:0] sum;
    logic [31:0] mix;
    mix = '0;
    for (int k = 0; k < 4; k++) begin
      sum = 11'(s2_r.src[8*k +: 8]) + 11'(s2_r.prod[k][15:7]) - 11'(s2_r.g);
      if (sum[10]) begin
        mix[8*k +: 8] = 8'd0;
      end else if (sum[9:8] != 2'b00) begin
        mix[8*k +: 8] = 8'd255;
      end else begin
        mix[8*k +: 8] = sum[7:0];
      end
    end
    if (s2_r.zero) begin
      res3_nxt = s2_r.dst;
    end else if (s2_r.full) begin
      res3_nxt = s2_r.src;
    end else begin
      res3_nxt = mix;
    end
    we3_nxt = !s2_r.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_ch.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      s1_r <= s1_nxt;
    end
    if (rdy2 && v1_r) begin
      s2_r <= s2_nxt;
    end
    if (rdy3 && v2_r) begin
      res3_r <= res3_nxt;
      we3_r  <= we3_nxt;
    end
  end

  assign out_ch.valid        = v3_r;
  assign out_ch.result_pixel = res3_r;
  assign out_ch.write_enable = we3_r;

  `ABP_ASSERT_NEXT(a_ga_write, clk, rst_n, ga_we, ga_r == $past(pwdata[abp_pkg::GA_W-1:0]))
  `ABP_ASSERT_NEXT(a_s1_to_s2, clk, rst_n, v1_r && rdy2, v2_r && (s2_r.src == $past(s1_r.src)))
  `ABP_ASSERT_NEXT(a_out_hold, clk, rst_n, v3_r && !out_ch.ready, v3_r)
  `ABP_ASSERT_NOW(a_flags_excl, clk, rst_n, v1_r && s1_r.full, !s1_r.zero)

endmodule

/* bench/tb_top.sv */
// Testbench for alpha_blend_argb32_pixel_top: random and directed ARGB blend beats,
// checked against an in-bench blend predictor. Depends on abp_pkg and abp_if.sv.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [abp_pkg::PIXEL_W-1:0] src;
    logic [abp_pkg::PIXEL_W-1:0] dst;
  } pixel_pair_t;

  typedef struct packed {
    logic [abp_pkg::PIXEL_W-1:0] pixel;
    logic                        write_en;
  } blend_result_t;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 10;
  localparam int DRAIN_CYCLES    = 6;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASE_COUNT     = 12;
  localparam int PHASE_BEATS     = 110;
  localparam int HOLD_BEATS      = 40;
  localparam int REG_SPARE_INDEX = 1;

  logic                         clk;
  logic                         rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [abp_pkg::ADDR_W-1:0]   paddr;
  logic [abp_pkg::DATA_W-1:0]   pwdata;
  logic [abp_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  abp_in_if  in_bus ();
  abp_out_if out_bus ();

  alpha_blend_argb32_pixel_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pixel_pair_t              pending_pixels[$];
  blend_result_t            expected_blends[$];
  logic [abp_pkg::GA_W-1:0] global_alpha_model = abp_pkg::GA_RESET;
  int                       sender_idle_pct = 0;
  int                       ready_stall_pct = 0;
  int                       hold_requests = 0;
  int                       hold_served = 0;
  int                       hold_left = 0;
  int                       error_count = 0;
  int                       quiet_cycles = 0;
  logic                     in_taken = 1'b0;
  logic                     out_taken = 1'b0;

  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic blend_result_t blend_pixel(input logic [abp_pkg::PIXEL_W-1:0] src,
                                                input logic [abp_pkg::PIXEL_W-1:0] dst,
                                                input logic [abp_pkg::GA_W-1:0]    ga);
    blend_result_t r;
    int eff;
    int g;
    int s;
    int d;
    int half;
    int v;
    eff = (int'(src[31:24]) * int'(ga)) >> 8;
    if (eff == 0) begin
      r.pixel    = dst;
      r.write_en = 1'b0;
    end else if (eff >= int'(abp_pkg::ALPHA_FULL)) begin
      r.pixel    = src;
      r.write_en = 1'b1;
    end else begin
      g = int'(abp_pkg::ALPHA_FULL) - eff;
      for (int k = 0; k < 4; k++) begin
        s    = int'(src[8*k +: 8]);
        d    = int'(dst[8*k +: 8]);
        half = (d + 255 - s) >> 1;
        v    = s + ((half * g) >> 7) - g;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        r.pixel[8*k +: 8] = 8'(v);
      end
      r.write_en = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [abp_pkg::PIXEL_W-1:0] random_source();
    logic [abp_pkg::PIXEL_W-1:0] p;
    p = $urandom();
    case ($urandom_range(7))
      0: p[31:24] = 8'h00;
      1: p[31:24] = 8'hFF;
      default: ;
    endcase
    return p;
  endfunction

  task automatic push_pixel(input logic [abp_pkg::PIXEL_W-1:0] src,
                            input logic [abp_pkg::PIXEL_W-1:0] dst);
    pixel_pair_t pp;
    pp.src = src;
    pp.dst = dst;
    pending_pixels.push_back(pp);
  endtask

  task automatic write_register(input int index, input logic [abp_pkg::DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= abp_pkg::ADDR_W'(index * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (index == int'(abp_pkg::REG_GLOBAL_ALPHA)) global_alpha_model = value[abp_pkg::GA_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || in_bus.valid || expected_blends.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_global_alpha(input logic [abp_pkg::GA_W-1:0] ga);
    write_register(int'(abp_pkg::REG_GLOBAL_ALPHA), {23'($urandom()), ga});
  endtask

  // sender: hold the beat until taken, then advance or idle
  always @(negedge clk) begin
    pixel_pair_t nxt;
    if (rst_n && (!in_bus.valid || in_taken)) begin
      if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = pending_pixels.pop_front();
        in_bus.valid        <= 1'b1;
        in_bus.source_pixel <= nxt.src;
        in_bus.dest_pixel   <= nxt.dst;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  always @(posedge clk) begin
    blend_result_t want;
    in_taken  = rst_n && in_bus.valid && in_bus.ready;
    out_taken = rst_n && out_bus.valid && out_bus.ready;
    if (out_taken) begin
      if (expected_blends.size() == 0) begin
        $display("%0t: unexpected beat result_pixel %h write_enable %b", $time,
                 out_bus.result_pixel, out_bus.write_enable);
        error_count++;
      end else begin
        want = expected_blends.pop_front();
        if (out_bus.result_pixel !== want.pixel) begin
          $display("%0t: result_pixel expected %h actual %h", $time, want.pixel,
                   out_bus.result_pixel);
          error_count++;
        end
        if (out_bus.write_enable !== want.write_en) begin
          $display("%0t: write_enable expected %b actual %b", $time, want.write_en,
                   out_bus.write_enable);
          error_count++;
        end
      end
    end
    if (in_taken)
      expected_blends.push_back(blend_pixel(in_bus.source_pixel, in_bus.dest_pixel,
                                            global_alpha_model));
    quiet_cycles = (in_taken || out_taken) ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [abp_pkg::GA_W-1:0] ga;
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_bus.valid        = 1'b0;
    in_bus.source_pixel = '0;
    in_bus.dest_pixel   = '0;
    out_bus.ready       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset global alpha: effective alpha equals source alpha
    push_pixel(32'h0000_0000, 32'hFFFF_FFFF);
    push_pixel(32'h00FF_FFFF, 32'hA5A5_A5A5);
    push_pixel(32'hFF00_0000, 32'h1234_5678);
    push_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    push_pixel(32'h0100_0000, 32'hFFFF_FFFF);
    push_pixel(32'h0100_0000, 32'h0000_0000);
    push_pixel(32'hFEFF_FFFF, 32'h0000_0000);
    push_pixel(32'h80FF_FFFF, 32'h0000_0000);
    push_pixel(32'h8000_0000, 32'hFFFF_FFFF);
    push_pixel(32'h7F55_AA55, 32'hAA55_AA55);
    push_pixel(32'hC8FF_00C8, 32'hFF00_FFFF);
    wait_drained();

    set_global_alpha(9'd0);
    push_pixel(32'hFFFF_FFFF, 32'h5A5A_5A5A);
    push_pixel(32'h8012_3456, 32'h0000_0000);
    wait_drained();

    set_global_alpha(9'd511);
    push_pixel(32'hFF00_FF00, 32'h00FF_00FF);
    push_pixel(32'h01AB_CDEF, 32'h1357_9BDF);
    push_pixel(32'h8080_8080, 32'h0000_0000);
    wait_drained();

    // write to an unmapped register must leave global alpha alone
    write_register(REG_SPARE_INDEX, 32'h0000_0000);
    push_pixel(32'h8080_8080, 32'h0000_0000);
    wait_drained();

    set_global_alpha(9'd1);
    push_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    wait_drained();
    set_global_alpha(9'd257);
    push_pixel(32'hFF11_2233, 32'hFFFF_FFFF);
    wait_drained();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: ga = 9'd256;
        1: ga = 9'd0;
        2: ga = 9'd511;
        3: ga = 9'd255;
        4: ga = 9'd1;
        5: ga = 9'd128;
        6: ga = 9'd200;
        default: ga = 9'($urandom_range(511));
      endcase
      set_global_alpha(ga);
      case (p % 4)
        0: begin sender_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin sender_idle_pct = 79; ready_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  ready_stall_pct = 79; end
        default: begin sender_idle_pct = 37; ready_stall_pct = 37; end
      endcase
      for (int i = 0; i < PHASE_BEATS; i++) push_pixel(random_source(), $urandom());
      wait_drained();

      if (p == 5) begin
        // hold the receiver off so the pipeline backs up into the input
        sender_idle_pct = 0;
        ready_stall_pct = 0;
        for (int i = 0; i < HOLD_BEATS; i++) push_pixel(random_source(), $urandom());
        hold_requests++;
        wait_drained();
      end
    end

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
